[design/arwt_pkg.sv]
// arwt_pkg: shared types and constants for the address range watch table
// holds the operation codes, status codes and the token control struct
// no dependencies; used by arwt_cell and address_range_watch_table_core
package arwt_pkg;

    // fixed field widths of the ports
    localparam int ADDR_W   = 52;
    localparam int END_IN_W = 53;
    localparam int FLAG_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // operation carried by each input transaction
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // control part of the token that walks down the cell chain
    typedef struct packed {
        logic              valid;      // token present at this position
        op_t               op;
        logic              bad;        // add with empty range
        logic              hit;        // duplicate, removed slot or lookup match seen
        logic              free_found; // a free slot was already claimed upstream
        logic [FLAG_W-1:0] flags;      // trap flags for add, match flags for lookup
    } ctrl_t;

endpackage

[design/arwt_cell.sv]
// arwt_cell: one slot of the watch table plus one stage of the token chain
// compares the passing token against its slot and hands it to the next cell
// depends on arwt_pkg
module arwt_cell #(
    parameter int START_W = 31,
    parameter int END_W   = 33
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  arwt_pkg::ctrl_t       ctrl_in,
    input  logic [START_W-1:0]    su_in,
    input  logic [END_W-1:0]      eu_in,
    input  logic                  commit,
    output arwt_pkg::ctrl_t       ctrl_out,
    output logic [START_W-1:0]    su_out,
    output logic [END_W-1:0]      eu_out
);

    arwt_pkg::ctrl_t             ctrl_reg, ctrl_next;
    logic [START_W-1:0]          su_reg;
    logic [END_W-1:0]            eu_reg;
    logic                        valid_reg, valid_next;
    logic                        pending_reg, pending_next;
    logic [START_W-1:0]          start_reg;
    logic [END_W-1:0]            end_reg;
    logic [arwt_pkg::FLAG_W-1:0] flags_reg;

    logic [END_W-1:0] su_ext;
    logic             start_eq;
    logic             dup_here;
    logic             look_here;
    logic             claim;

    // slot compares
    assign su_ext    = {{(END_W-START_W){1'b0}}, su_in};
    assign start_eq  = valid_reg && (start_reg == su_in);
    assign dup_here  = start_eq && (end_reg == eu_in);
    assign look_here = valid_reg && (su_in >= start_reg) && (su_ext < end_reg);
    assign claim     = ctrl_in.valid && (ctrl_in.op == arwt_pkg::OP_ADD) && !ctrl_in.bad
                       && !valid_reg && !ctrl_in.free_found;

    // token update and slot state update
    always_comb
    begin
        ctrl_next    = ctrl_in;
        valid_next   = valid_reg;
        pending_next = pending_reg;
        if (ctrl_in.valid)
        begin
            pending_next = claim;
            unique case (ctrl_in.op)
                arwt_pkg::OP_ADD:
                begin
                    if (!ctrl_in.bad)
                    begin
                        ctrl_next.hit        = ctrl_in.hit | dup_here;
                        ctrl_next.free_found = ctrl_in.free_found | !valid_reg;
                    end
                end
                arwt_pkg::OP_REMOVE:
                begin
                    if (!ctrl_in.hit && start_eq)
                    begin
                        valid_next    = 1'b0;
                        ctrl_next.hit = 1'b1;
                    end
                end
                arwt_pkg::OP_LOOKUP:
                begin
                    if (!ctrl_in.hit && look_here)
                    begin
                        ctrl_next.hit   = 1'b1;
                        ctrl_next.flags = flags_reg;
                    end
                end
                arwt_pkg::OP_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
        else if (commit)
        begin
            // the claimed slot goes live once the whole chain saw no duplicate
            valid_next   = valid_reg | pending_reg;
            pending_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg    <= '0;
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg    <= ctrl_next;
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
        end
    end

    // token payload and slot contents
    always_ff @(posedge clk)
    begin
        su_reg <= su_in;
        eu_reg <= eu_in;
        if (claim)
        begin
            start_reg <= su_in;
            end_reg   <= eu_in;
            flags_reg <= ctrl_in.flags;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign su_out   = su_reg;
    assign eu_out   = eu_reg;

endmodule

[design/address_range_watch_table_core.sv]
// address_range_watch_table_core: top level of the address range watch table
// prepares each transaction, runs it down a chain of arwt_cell slots, commits
// depends on arwt_pkg and arwt_cell
//
// Usage:
//   Input channel in_valid/in_ready carries mode, addr_start, addr_end and
//   trap_flags; output channel out_valid/out_ready returns status,
//   match_flags and active_count, one result per input transaction.
//   A transaction is registered, its region units are computed into the
//   head token, then a token walks the chain of ENTRIES cells, one cell per
//   cycle, and the result is committed and loaded into the output register.
//   One transaction is in flight at a time and in_ready returns in the
//   cycle after the result is loaded, so throughput is set by the length
//   of the cell chain.
//   in_ready is high only while no transaction is in flight. A result that
//   waits on out_ready does not block acceptance; a finished transaction
//   holds before commit until the previous result is taken.
//   Reset empties the table (all slots invalid, count zero) and drops any
//   transaction in flight; slot contents are not cleared.
module address_range_watch_table_core #(
    parameter int ENTRIES      = 64,
    parameter int REGION_SHIFT = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [arwt_pkg::ADDR_W-1:0]   addr_start,
    input  logic [arwt_pkg::END_IN_W-1:0] addr_end,
    input  logic [arwt_pkg::FLAG_W-1:0]   trap_flags,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [arwt_pkg::STATUS_W-1:0] status,
    output logic [arwt_pkg::FLAG_W-1:0]   match_flags,
    output logic [arwt_pkg::COUNT_W-1:0]  active_count
);

    localparam int START_W = arwt_pkg::ADDR_W - REGION_SHIFT;
    localparam int SUM_W   = arwt_pkg::END_IN_W + 1;
    localparam int END_W   = SUM_W - REGION_SHIFT;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam logic [SUM_W-1:0] REGION_MASK = (SUM_W'(1) << REGION_SHIFT) - SUM_W'(1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_RUN  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // request registers
    logic [1:0]                    mode_reg;
    logic [arwt_pkg::ADDR_W-1:0]   start_reg;
    logic [arwt_pkg::END_IN_W-1:0] end_reg;
    logic [arwt_pkg::FLAG_W-1:0]   tflags_reg;

    // token injected at the head of the chain
    arwt_pkg::ctrl_t    inj_ctrl_reg, inj_ctrl_next;
    logic [START_W-1:0] inj_su_reg;
    logic [END_W-1:0]   inj_eu_reg;

    // token captured at the tail of the chain
    arwt_pkg::ctrl_t    done_reg;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [arwt_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [arwt_pkg::FLAG_W-1:0]   match_reg, match_next;

    logic [SUM_W-1:0]   end_sum;
    logic               range_bad;
    logic               in_fire;
    logic               out_load;
    logic               commit_add;
    logic [CNT_W+arwt_pkg::COUNT_W-1:0] cnt_ext;

    arwt_pkg::ctrl_t    chain_ctrl [ENTRIES+1];
    logic [START_W-1:0] chain_su   [ENTRIES+1];
    logic [END_W-1:0]   chain_eu   [ENTRIES+1];

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // region alignment of the captured request
    assign end_sum   = {1'b0, end_reg} + REGION_MASK;
    assign range_bad = ({1'b0, start_reg} >= end_reg);

    // head token
    always_comb
    begin
        inj_ctrl_next            = '0;
        inj_ctrl_next.valid      = (state_reg == S_PREP);
        inj_ctrl_next.op         = arwt_pkg::op_t'(mode_reg);
        inj_ctrl_next.bad        = (arwt_pkg::op_t'(mode_reg) == arwt_pkg::OP_ADD) && range_bad;
        inj_ctrl_next.flags      = (arwt_pkg::op_t'(mode_reg) == arwt_pkg::OP_ADD) ?
                                   tflags_reg : '0;
    end

    assign chain_ctrl[0] = inj_ctrl_reg;
    assign chain_su[0]   = inj_su_reg;
    assign chain_eu[0]   = inj_eu_reg;

    // row of table cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        arwt_cell #(
            .START_W (START_W),
            .END_W   (END_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (chain_ctrl[i]),
            .su_in    (chain_su[i]),
            .eu_in    (chain_eu[i]),
            .commit   (commit_add),
            .ctrl_out (chain_ctrl[i+1]),
            .su_out   (chain_su[i+1]),
            .eu_out   (chain_eu[i+1])
        );
    end

    // commit decision and result
    always_comb
    begin
        commit_add     = 1'b0;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        match_next     = match_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            status_next    = arwt_pkg::ST_OK;
            match_next     = '0;
            unique case (done_reg.op)
                arwt_pkg::OP_ADD:
                begin
                    if (done_reg.bad)
                    begin
                        status_next = arwt_pkg::ST_INVALID;
                    end
                    else if (!done_reg.hit)
                    begin
                        if (done_reg.free_found)
                        begin
                            commit_add = 1'b1;
                            cnt_next   = cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            status_next = arwt_pkg::ST_FULL;
                        end
                    end
                end
                arwt_pkg::OP_REMOVE:
                begin
                    if (done_reg.hit)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = arwt_pkg::ST_NOT_FOUND;
                    end
                end
                arwt_pkg::OP_LOOKUP:
                begin
                    match_next = done_reg.flags;
                end
                arwt_pkg::OP_CLEAR:
                begin
                    cnt_next = '0;
                end
                default:
                begin
                    cnt_next = cnt_reg;
                end
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (chain_ctrl[ENTRIES].valid)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            inj_ctrl_reg  <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inj_ctrl_reg  <= inj_ctrl_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg   <= mode;
            start_reg  <= addr_start;
            end_reg    <= addr_end;
            tflags_reg <= trap_flags;
        end
        inj_su_reg <= start_reg[arwt_pkg::ADDR_W-1:REGION_SHIFT];
        inj_eu_reg <= end_sum[SUM_W-1:REGION_SHIFT];
        if ((state_reg == S_RUN) && chain_ctrl[ENTRIES].valid)
        begin
            done_reg <= chain_ctrl[ENTRIES];
        end
        status_reg <= status_next;
        match_reg  <= match_next;
    end

    // outputs, count reported modulo 128
    assign cnt_ext      = {{arwt_pkg::COUNT_W{1'b0}}, cnt_reg};
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign match_flags  = match_reg;
    assign active_count = cnt_ext[arwt_pkg::COUNT_W-1:0];

    // checks
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CNT_W'(ENTRIES))
        else $error("valid count exceeds table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        commit_add |-> (cnt_reg < CNT_W'(ENTRIES)))
        else $error("add committed into a full table");

    assert property (@(posedge clk) disable iff (!rst_n)
        chain_ctrl[ENTRIES].valid |-> (state_reg == S_RUN))
        else $error("token left the chain outside the run phase");

    assert property (@(posedge clk) disable iff (!rst_n) out_load |=> out_valid_reg)
        else $error("result load did not raise out_valid");

endmodule

[dv/address_range_watch_table_core_tb.sv]
// testbench for address_range_watch_table_core: directed and random table operations
// with a self-contained table predictor and an in-order result scoreboard
// depends on arwt_pkg and the address_range_watch_table_core rtl
`timescale 1ns / 100ps

module address_range_watch_table_core_tb;

    localparam int          ENTRIES      = 64;
    localparam int          REGION_SHIFT = 21;
    localparam int          CLK_PERIOD   = 8;
    localparam int          ADDR_W       = arwt_pkg::ADDR_W;
    localparam int          END_IN_W     = arwt_pkg::END_IN_W;
    localparam int          FLAG_W       = arwt_pkg::FLAG_W;
    localparam int          STATUS_W     = arwt_pkg::STATUS_W;
    localparam int          COUNT_W      = arwt_pkg::COUNT_W;
    localparam longint      TIMEOUT_NS   = 10_000_000;
    localparam logic [63:0] REGION_MASK  = (64'd1 << REGION_SHIFT) - 64'd1;
    localparam logic [63:0] ADDR_MASK    = (64'd1 << ADDR_W) - 64'd1;
    localparam logic [63:0] ADDR_LIMIT   = 64'd1 << ADDR_W;
    localparam logic [FLAG_W-1:0] FLAG_NONE  = 2'b00;
    localparam logic [FLAG_W-1:0] FLAG_EXEC  = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_WRITE = 2'b10;

    // one expected result per accepted transaction
    typedef struct packed {
        arwt_pkg::op_t       op;
        logic [STATUS_W-1:0] status;
        logic [FLAG_W-1:0]   match_flags;
        logic [COUNT_W-1:0]  active_count;
    } watch_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          mode;
    logic [ADDR_W-1:0]   addr_start;
    logic [END_IN_W-1:0] addr_end;
    logic [FLAG_W-1:0]   trap_flags;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [FLAG_W-1:0]   match_flags;
    logic [COUNT_W-1:0]  active_count;

    // predicted table contents, units of regions
    logic        tbl_valid [ENTRIES];
    logic [63:0] tbl_start [ENTRIES];
    logic [63:0] tbl_end   [ENTRIES];
    logic [1:0]  tbl_flags [ENTRIES];
    int          tbl_count;

    watch_result_t pending_results[$];
    int            fail_count;
    bit            idle_en;

    address_range_watch_table_core #(
        .ENTRIES      (ENTRIES),
        .REGION_SHIFT (REGION_SHIFT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .addr_start   (addr_start),
        .addr_end     (addr_end),
        .trap_flags   (trap_flags),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .match_flags  (match_flags),
        .active_count (active_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void note_failure(string what);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // table predictor: applies one operation and returns the expected result
    function automatic watch_result_t apply_table_op(arwt_pkg::op_t op,
                                                     logic [ADDR_W-1:0] a,
                                                     logic [END_IN_W-1:0] e,
                                                     logic [FLAG_W-1:0] f);
        watch_result_t r;
        logic [63:0]   su;
        logic [63:0]   eu;
        int            free_idx;
        bit            done;
        r          = '0;
        r.op       = op;
        su         = 64'(a) >> REGION_SHIFT;
        eu         = (64'(e) + REGION_MASK) >> REGION_SHIFT;
        free_idx   = -1;
        done       = 1'b0;
        r.status   = arwt_pkg::ST_OK;
        case (op)
            arwt_pkg::OP_ADD:
            begin
                if (a >= e)
                    r.status = arwt_pkg::ST_INVALID;
                else
                begin
                    // an exact duplicate wins over claiming a free slot
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (tbl_valid[i] && tbl_start[i] == su && tbl_end[i] == eu)
                            done = 1'b1;
                        if (!tbl_valid[i] && free_idx < 0)
                            free_idx = i;
                    end
                    if (!done)
                    begin
                        if (free_idx < 0)
                            r.status = arwt_pkg::ST_FULL;
                        else
                        begin
                            tbl_valid[free_idx] = 1'b1;
                            tbl_start[free_idx] = su;
                            tbl_end[free_idx]   = eu;
                            tbl_flags[free_idx] = f;
                            tbl_count++;
                        end
                    end
                end
            end
            arwt_pkg::OP_REMOVE:
            begin
                r.status = arwt_pkg::ST_NOT_FOUND;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!done && tbl_valid[i] && tbl_start[i] == su)
                    begin
                        tbl_valid[i] = 1'b0;
                        tbl_count--;
                        r.status = arwt_pkg::ST_OK;
                        done     = 1'b1;
                    end
                end
            end
            arwt_pkg::OP_LOOKUP:
            begin
                // lowest valid slot containing the address
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!done && tbl_valid[i] && su >= tbl_start[i] && su < tbl_end[i])
                    begin
                        r.match_flags = tbl_flags[i];
                        done          = 1'b1;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    tbl_valid[i] = 1'b0;
                tbl_count = 0;
            end
        endcase
        r.active_count = COUNT_W'(tbl_count);
        return r;
    endfunction

    // address helpers
    function automatic logic [ADDR_W-1:0] region(longint unsigned units);
        return ADDR_W'(units << REGION_SHIFT);
    endfunction

    function automatic logic [ADDR_W-1:0] low_bits();
        return ADDR_W'(64'($urandom) & REGION_MASK);
    endfunction

    function automatic logic [ADDR_W-1:0] rand52();
        return ADDR_W'({$urandom, $urandom} & ADDR_MASK);
    endfunction

    function automatic logic [END_IN_W-1:0] rand_end();
        return END_IN_W'(64'(rand52()) + 64'($urandom_range(0, 1)));
    endfunction

    // mostly a small window of regions so that ranges collide, sometimes near the top or anywhere
    function automatic logic [ADDR_W-1:0] pick_start();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 2)
            return rand52();
        else if (sel == 2)
            return region((64'd1 << (ADDR_W - REGION_SHIFT)) - 64'd1 - 64'($urandom_range(0, 7)))
                   | low_bits();
        else
            return region($urandom_range(0, 47)) | low_bits();
    endfunction

    // exclusive end for an add: mostly a short range, sometimes empty, reversed, random or at the limit
    function automatic logic [END_IN_W-1:0] pick_end(logic [ADDR_W-1:0] a);
        logic [63:0] e;
        logic [63:0] delta;
        int unsigned sel;
        sel   = $urandom_range(0, 19);
        delta = 64'($urandom_range(1, 3000000));
        if (sel == 0)
            e = ADDR_LIMIT;
        else if (sel == 1)
            e = 64'(a);
        else if (sel == 2)
            e = (64'(a) > delta) ? 64'(a) - delta : 64'd0;
        else if (sel == 3)
            e = 64'(rand52()) + 64'd1;
        else
            e = 64'(a) + (64'($urandom_range(0, 5)) << REGION_SHIFT)
                + (64'($urandom) & REGION_MASK) + 64'd1;
        if (e > ADDR_LIMIT)
            e = ADDR_LIMIT;
        return END_IN_W'(e);
    endfunction

    // send one transaction; valid stays high after acceptance until the next call
    task automatic send_op(arwt_pkg::op_t op, logic [ADDR_W-1:0] a,
                           logic [END_IN_W-1:0] e, logic [FLAG_W-1:0] f);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        addr_start <= a;
        addr_end   <= e;
        trap_flags <= f;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(apply_table_op(op, a, e, f));
    endtask

    // drop valid and hold off until every expected result is back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_op();
        int unsigned       pick;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(0, 99);
        a    = pick_start();
        if (pick < 45)
            send_op(arwt_pkg::OP_ADD, a, pick_end(a), 2'($urandom));
        else if (pick < 60)
            send_op(arwt_pkg::OP_REMOVE, a, rand_end(), 2'($urandom));
        else if (pick < 99)
            send_op(arwt_pkg::OP_LOOKUP, a, rand_end(), 2'($urandom));
        else
            send_op(arwt_pkg::OP_CLEAR, a, rand_end(), 2'($urandom));
    endtask

    // empty table, empty and reversed ranges, duplicates, overlaps and field extremes
    task automatic test_directed_cases();
        send_op(arwt_pkg::OP_LOOKUP, '0, rand_end(), 2'($urandom));
        send_op(arwt_pkg::OP_REMOVE, '0, rand_end(), 2'($urandom));
        send_op(arwt_pkg::OP_CLEAR, rand52(), rand_end(), 2'($urandom));
        send_op(arwt_pkg::OP_ADD, '0, '0, FLAG_EXEC | FLAG_WRITE);
        send_op(arwt_pkg::OP_ADD, '1, '0, FLAG_EXEC);
        // zero flags, then a duplicate after alignment keeps them
        send_op(arwt_pkg::OP_ADD, 52'h1000, 53'h1001, FLAG_NONE);
        send_op(arwt_pkg::OP_ADD, '0, END_IN_W'(region(1)), FLAG_EXEC | FLAG_WRITE);
        send_op(arwt_pkg::OP_LOOKUP, region(1) - 1, rand_end(), 2'($urandom));
        // top of the address space
        send_op(arwt_pkg::OP_ADD, '1, END_IN_W'(ADDR_LIMIT), FLAG_EXEC | FLAG_WRITE);
        send_op(arwt_pkg::OP_LOOKUP, '1, rand_end(), 2'($urandom));
        // overlapping ranges, lowest slot wins
        send_op(arwt_pkg::OP_ADD, region(2), END_IN_W'(region(5)) + 1, FLAG_EXEC);
        send_op(arwt_pkg::OP_ADD, region(4), END_IN_W'(region(8)), FLAG_WRITE);
        send_op(arwt_pkg::OP_LOOKUP, region(4), rand_end(), 2'($urandom));
        send_op(arwt_pkg::OP_LOOKUP, region(6) | low_bits(), rand_end(), 2'($urandom));
        send_op(arwt_pkg::OP_LOOKUP, region(8), rand_end(), 2'($urandom));
        // remove by unaligned start, then again with nothing left to remove
        send_op(arwt_pkg::OP_REMOVE, region(2) | low_bits(), rand_end(), 2'($urandom));
        send_op(arwt_pkg::OP_LOOKUP, region(4), rand_end(), 2'($urandom));
        send_op(arwt_pkg::OP_REMOVE, region(2), rand_end(), 2'($urandom));
        // freed slot is reused ahead of later slots
        send_op(arwt_pkg::OP_ADD, region(7), END_IN_W'(region(7)) + 1,
                FLAG_EXEC | FLAG_WRITE);
        send_op(arwt_pkg::OP_LOOKUP, region(7), rand_end(), 2'($urandom));
        send_op(arwt_pkg::OP_ADD, '1, END_IN_W'(ADDR_LIMIT), FLAG_NONE);
        send_op(arwt_pkg::OP_CLEAR, '0, '0, '0);
        send_op(arwt_pkg::OP_LOOKUP, '0, rand_end(), 2'($urandom));
        send_op(arwt_pkg::OP_REMOVE, '1, rand_end(), 2'($urandom));
    endtask

    // fill every slot, then full, duplicate while full and slot reuse
    task automatic test_table_full();
        send_op(arwt_pkg::OP_CLEAR, rand52(), rand_end(), 2'($urandom));
        for (int i = 0; i < ENTRIES; i++)
            send_op(arwt_pkg::OP_ADD, region(2 * i) | low_bits(),
                    END_IN_W'(region(2 * i + 1)), 2'($urandom));
        send_op(arwt_pkg::OP_ADD, region(200), END_IN_W'(region(201)), FLAG_EXEC);
        send_op(arwt_pkg::OP_ADD, region(10), END_IN_W'(region(11)), FLAG_EXEC | FLAG_WRITE);
        send_op(arwt_pkg::OP_REMOVE, region(20) | low_bits(), rand_end(), 2'($urandom));
        send_op(arwt_pkg::OP_ADD, region(0), END_IN_W'(region(300)), FLAG_EXEC | FLAG_WRITE);
        send_op(arwt_pkg::OP_LOOKUP, region(21), rand_end(), 2'($urandom));
        send_op(arwt_pkg::OP_LOOKUP, region(4) | low_bits(), rand_end(), 2'($urandom));
        send_op(arwt_pkg::OP_ADD, region(400), END_IN_W'(region(401)), FLAG_NONE);
        send_op(arwt_pkg::OP_CLEAR, rand52(), rand_end(), 2'($urandom));
    endtask

    // random mix with a full drain half way through
    task automatic test_random_mix(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                wait_drained();
            send_random_op();
        end
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_quiet_tail(int n);
        idle_en = 1'b0;
        repeat (n) send_random_op();
    endtask

    // result checker, in order against the oldest expectation
    always @(posedge clk)
    begin : result_check
        watch_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected result status=%0d flags=%0d count=%0d",
                                       status, match_flags, active_count));
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    note_failure($sformatf("%s status expected %0d got %0d",
                                           want.op.name(), want.status, status));
                if (match_flags !== want.match_flags)
                    note_failure($sformatf("%s match_flags expected %0d got %0d",
                                           want.op.name(), want.match_flags, match_flags));
                if (active_count !== want.active_count)
                    note_failure($sformatf("%s active_count expected %0d got %0d",
                                           want.op.name(), want.active_count, active_count));
            end
        end
    end

    // receiver back-pressure in random bursts
    initial
    begin : ready_driver
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // hard limit on run time
    initial
    begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = arwt_pkg::OP_ADD;
        addr_start = '0;
        addr_end   = '0;
        trap_flags = '0;
        idle_en    = 1'b1;
        fail_count = 0;
        tbl_count  = 0;
        for (int i = 0; i < ENTRIES; i++)
            tbl_valid[i] = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_table_full();
        test_random_mix(950);
        test_quiet_tail(100);

        wait_drained();
        repeat (ENTRIES + 16) @(posedge clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
